// File: sv/qlbs_pkg.sv
// Shared constants, command types and codes for the queued LED blink sequencer.
package qlbs_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FILL_W      = 4;
	localparam int TIMES_W     = 8;
	localparam int DELAY_W     = 16;
	localparam int SPAN_W      = 18;
	localparam int CLOSE_SHIFT = 2;

	localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_ENQUEUE = 2'd1;
	localparam logic [1:0] FUNC_LED_ON  = 2'd2;
	localparam logic [1:0] FUNC_LED_OFF = 2'd3;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_ENQUEUE,
		OP_LED_ON,
		OP_LED_OFF
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [TIMES_W-1:0] times;
		logic [DELAY_W-1:0] delay_ticks;
		logic               force_req;
	} cmd_t;

	typedef struct packed {
		logic [TIMES_W-1:0] times;
		logic [DELAY_W-1:0] delay_ticks;
	} req_t;

endpackage

// File: sv/qlbs_front.sv
// Front stage: accepts input items and classifies them into commands.
module qlbs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [qlbs_pkg::TIMES_W-1:0]    times,
	input  logic [qlbs_pkg::DELAY_W-1:0]    delay_ticks,
	input  logic                            force_req,
	output logic                            push_valid,
	input  logic                            push_ready,
	output qlbs_pkg::cmd_t                  push_cmd
);

	logic           valid_s1;
	qlbs_pkg::cmd_t cmd_s1;
	qlbs_pkg::op_t  op_dec;

	always_comb begin
		case (func)
			qlbs_pkg::FUNC_TICK:    op_dec = qlbs_pkg::OP_TICK;
			qlbs_pkg::FUNC_ENQUEUE: op_dec = qlbs_pkg::OP_ENQUEUE;
			qlbs_pkg::FUNC_LED_ON:  op_dec = qlbs_pkg::OP_LED_ON;
			qlbs_pkg::FUNC_LED_OFF: op_dec = qlbs_pkg::OP_LED_OFF;
			default:                op_dec = qlbs_pkg::OP_TICK;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.op          <= op_dec;
			cmd_s1.times       <= times;
			cmd_s1.delay_ticks <= delay_ticks;
			cmd_s1.force_req   <= force_req;
		end
	end

endmodule

// File: sv/qlbs_cmd_fifo.sv
// Two-entry command queue between the front and back stages.
module qlbs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  qlbs_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output qlbs_pkg::cmd_t pop_cmd
);

	qlbs_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: sv/qlbs_back.sv
// Back stage: request queue, blink timing state and the result register.
module qlbs_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  qlbs_pkg::cmd_t                 cmd,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           led_level,
	output logic                           busy_res,
	output logic                           accepted,
	output logic [qlbs_pkg::FILL_W-1:0]    queue_fill
);

	// Blink state
	logic                           led_q, active_q, lit_q, closing_q;
	logic [qlbs_pkg::TIMES_W-1:0]   done_q, target_q;
	logic [qlbs_pkg::SPAN_W-1:0]    period_q, elapsed_q;
	logic [qlbs_pkg::PTR_W-1:0]     head_q, tail_q;
	logic [qlbs_pkg::CNT_W-1:0]     fill_q;
	qlbs_pkg::req_t                 store_q [qlbs_pkg::QUEUE_DEPTH];

	// Next state
	logic                           led_n, active_n, lit_n, closing_n;
	logic [qlbs_pkg::TIMES_W-1:0]   done_n, target_n;
	logic [qlbs_pkg::SPAN_W-1:0]    period_n, elapsed_n;
	logic [qlbs_pkg::PTR_W-1:0]     head_n, tail_n;
	logic [qlbs_pkg::CNT_W-1:0]     fill_n;
	logic                           acc_n;
	logic                           wr_en;
	logic                           take;
	logic                           last_blink;
	logic [qlbs_pkg::TIMES_W:0]     done_inc;
	qlbs_pkg::req_t                 head_req;

	// Result register
	logic                           out_valid_q;
	logic                           res_led_q, res_busy_q, res_acc_q;
	logic [qlbs_pkg::FILL_W-1:0]    res_fill_q;

	assign cmd_ready = !out_valid_q || out_ready;
	assign take      = cmd_valid && cmd_ready;
	assign head_req  = store_q[head_q];

	always_comb begin
		led_n      = led_q;
		active_n   = active_q;
		lit_n      = lit_q;
		closing_n  = closing_q;
		done_n     = done_q;
		target_n   = target_q;
		period_n   = period_q;
		elapsed_n  = elapsed_q;
		head_n     = head_q;
		tail_n     = tail_q;
		fill_n     = fill_q;
		acc_n      = 1'b0;
		wr_en      = 1'b0;
		done_inc   = {1'b0, done_q} + {{qlbs_pkg::TIMES_W{1'b0}}, 1'b1};
		last_blink = 1'b0;
		case (cmd.op)
			qlbs_pkg::OP_TICK: begin
				if (active_q && elapsed_q != qlbs_pkg::SPAN_MAX) begin
					elapsed_n = elapsed_q + 1'b1;
				end
				// Start the waiting request when idle
				if (!active_q && fill_q != '0) begin
					target_n  = head_req.times;
					period_n  = {{(qlbs_pkg::SPAN_W-qlbs_pkg::DELAY_W){1'b0}},
						head_req.delay_ticks};
					head_n    = (head_q == qlbs_pkg::PTR_W'(qlbs_pkg::QUEUE_DEPTH - 1))
						? '0 : head_q + 1'b1;
					fill_n    = fill_q - 1'b1;
					elapsed_n = '0;
					led_n     = 1'b1;
					lit_n     = 1'b1;
					active_n  = 1'b1;
					done_n    = '0;
					closing_n = 1'b0;
				end
				last_blink = (done_inc >= {1'b0, target_n});
				if (active_n && elapsed_n > period_n) begin
					if (closing_n) begin
						closing_n = 1'b0;
						active_n  = 1'b0;
					end else if (lit_n) begin
						lit_n     = 1'b0;
						led_n     = 1'b0;
						elapsed_n = '0;
						if (last_blink) begin
							period_n  = period_n << qlbs_pkg::CLOSE_SHIFT;
							closing_n = 1'b1;
						end
					end else begin
						done_n    = done_n + 1'b1;
						lit_n     = 1'b1;
						led_n     = 1'b1;
						elapsed_n = '0;
					end
				end
			end
			qlbs_pkg::OP_ENQUEUE: begin
				if (fill_q < qlbs_pkg::CNT_W'(qlbs_pkg::QUEUE_DEPTH)) begin
					wr_en  = 1'b1;
					tail_n = (tail_q == qlbs_pkg::PTR_W'(qlbs_pkg::QUEUE_DEPTH - 1))
						? '0 : tail_q + 1'b1;
					fill_n = fill_q + 1'b1;
					acc_n  = 1'b1;
				end
			end
			qlbs_pkg::OP_LED_ON: begin
				if (cmd.force_req || !active_q) begin
					led_n = 1'b1;
				end
			end
			qlbs_pkg::OP_LED_OFF: begin
				if (cmd.force_req || !active_q) begin
					led_n = 1'b0;
				end
			end
			default: begin
				led_n = led_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q       <= 1'b0;
			active_q    <= 1'b0;
			lit_q       <= 1'b1;
			closing_q   <= 1'b0;
			done_q      <= '0;
			target_q    <= '0;
			period_q    <= '0;
			elapsed_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				led_q     <= led_n;
				active_q  <= active_n;
				lit_q     <= lit_n;
				closing_q <= closing_n;
				done_q    <= done_n;
				target_q  <= target_n;
				period_q  <= period_n;
				elapsed_q <= elapsed_n;
				head_q    <= head_n;
				tail_q    <= tail_n;
				fill_q    <= fill_n;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			store_q[tail_q] <= '{times: cmd.times, delay_ticks: cmd.delay_ticks};
		end
		if (take) begin
			res_led_q  <= led_n;
			res_busy_q <= active_n;
			res_acc_q  <= acc_n;
			res_fill_q <= qlbs_pkg::FILL_W'(fill_n);
		end
	end

	assign out_valid  = out_valid_q;
	assign led_level  = res_led_q;
	assign busy_res   = res_busy_q;
	assign accepted   = res_acc_q;
	assign queue_fill = res_fill_q;

endmodule

// File: sv/queued_led_blink_sequencer_unit.sv
// Top level of the queued LED blink sequencer: front stage, command queue, back stage.
// Each input item (tick, enqueue, LED on, LED off) yields exactly one result item that
// shows the LED level, the busy flag, the enqueue acceptance and the request queue fill
// after that item. One item is taken per clock while out_ready stays high; an item's
// result passes through the input register, the two-entry command queue and the
// result register, and the back stage updates all counters and flags of the blink state
// together when it takes a command. The request queue holds eight requests.
module queued_led_blink_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [qlbs_pkg::TIMES_W-1:0]    times,
	input  logic [qlbs_pkg::DELAY_W-1:0]    delay_ticks,
	input  logic                            force_req,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            led_level,
	output logic                            busy_res,
	output logic                            accepted,
	output logic [qlbs_pkg::FILL_W-1:0]     queue_fill
);

	logic           push_valid, push_ready;
	logic           pop_valid, pop_ready;
	qlbs_pkg::cmd_t push_cmd, pop_cmd;

	qlbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.times       (times),
		.delay_ticks (delay_ticks),
		.force_req   (force_req),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd)
	);

	qlbs_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	qlbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (pop_valid),
		.cmd_ready  (pop_ready),
		.cmd        (pop_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.led_level  (led_level),
		.busy_res   (busy_res),
		.accepted   (accepted),
		.queue_fill (queue_fill)
	);

endmodule
